// ===== rtl/bwtb_pkg.sv =====
// shared constants, codes and payload types of the bilinear texel blender
package bwtb_pkg;

  localparam int GRID_MAX   = 64;
  localparam int GRID_SIDE  = GRID_MAX + 1;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int COORD_W    = $clog2(GRID_SIDE + 1);

  localparam int STEP_W     = 24;
  localparam int DIM_W      = 7;
  localparam int LIDX_W     = 13;
  localparam int PIX_W      = 16;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1024);
  localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(64);
  localparam logic [15:0]       FULL_WEIGHT = 16'd65280;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STEP      = 2'd0,
    CFG_Y_STEP      = 2'd1,
    CFG_GRID_WIDTH  = 2'd2,
    CFG_GRID_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t              opcode;
    logic [LIDX_W-1:0] load_index;
    logic [CH_W-1:0]  load_weight;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [CH_W-1:0]  src_red;
    logic [CH_W-1:0]  src_green;
    logic [CH_W-1:0]  src_blue;
    logic [CH_W-1:0]  bg_red;
    logic [CH_W-1:0]  bg_green;
    logic [CH_W-1:0]  bg_blue;
  } in_item_t;

  typedef struct packed {
    logic             write_back;
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
  } out_item_t;

endpackage

// ===== rtl/bwtb_in_if.sv =====
// input channel: valid/ready handshake carrying one load or blend item
interface bwtb_in_if import bwtb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bwtb_out_if.sv =====
// result channel: valid/ready handshake carrying one blended pixel
interface bwtb_out_if import bwtb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bilinear_weighted_texel_blend.sv =====
// top level: eight-stage bilinear weight lookup and per-channel blend pipeline
//
// in_ch takes two kinds of items. A load (opcode 0) writes one byte of the
// weight grid and produces no result. A blend (opcode 1) produces exactly one
// result on out_ch: the pixel position echoed, write_back and the blended rgb.
// Load the grid before blending; blends see every load accepted before them.
// Configuration (step registers and grid size) is written through cfg_we,
// cfg_index and cfg_data while no item is in flight.
// Throughput is one item per cycle unless out_ch stalls. The four corner
// weights are fetched in one stage from two copies of the grid memory, each
// read at two addresses, and no stage holds two multiplies in series.
// A blend moves through the stage 1 to 8 registers in order to out_ch. Each
// stage holds when the stage after it is full and stalled, so a stalled
// receiver backs up the pipe one stage at a time and in_ch.ready falls only
// once every stage is occupied; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) empties the pipe and restores the registers
// to x_step = y_step = 1024 and a 64 by 64 grid. The grid memory is not
// cleared: every entry must be loaded before a blend reads it.
module bilinear_weighted_texel_blend import bwtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bwtb_in_if.sink               in_ch,
  bwtb_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = PIX_W + STEP_W;
  localparam int CI_W   = PROD_W - 15;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [CH_W-1:0]  sr;
    logic [CH_W-1:0]  sg;
    logic [CH_W-1:0]  sb;
    logic [CH_W-1:0]  br;
    logic [CH_W-1:0]  bgc;
    logic [CH_W-1:0]  bb;
  } pix_t;

  typedef struct packed {
    op_t               op;
    logic [LIDX_W-1:0] lidx;
    logic [CH_W-1:0]   lwt;
    pix_t              pix;
    logic [PROD_W-1:0] gx;
    logic [PROD_W-1:0] gy;
  } s1_t;

  typedef struct packed {
    op_t               op;
    logic [LIDX_W-1:0] lidx;
    logic [CH_W-1:0]   lwt;
    pix_t              pix;
    coord_t            x0;
    coord_t            x1;
    coord_t            y0;
    coord_t            y1;
    logic [15:0]       fx;
    logic [15:0]       fy;
  } s2_t;

  typedef struct packed {
    op_t               op;
    logic [LIDX_W-1:0] lidx;
    logic [CH_W-1:0]   lwt;
    pix_t              pix;
    addr_t             a00;
    addr_t             a10;
    addr_t             a01;
    addr_t             a11;
    logic [15:0]       fx;
    logic [15:0]       fy;
  } s3_t;

  typedef struct packed {
    op_t         op;
    pix_t        pix;
    logic [15:0] fx;
    logic [15:0] fy;
  } s4_t;

  typedef struct packed {
    pix_t        pix;
    logic [23:0] top;
    logic [23:0] bot;
    logic [15:0] fy;
  } s5_t;

  typedef struct packed {
    pix_t        pix;
    logic [15:0] w;
  } s6_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [23:0]      nr;
    logic [23:0]      ng;
    logic [23:0]      nb;
    logic             nz;
  } s7_t;

  function automatic coord_t eff_size(input logic [DIM_W-1:0] r);
    coord_t res;
    if (r == '0) begin
      res = COORD_W'(1);
    end else if (int'(r) > GRID_MAX) begin
      res = COORD_W'(GRID_MAX);
    end else begin
      res = COORD_W'(r);
    end
    return res;
  endfunction

  function automatic coord_t sat_coord(input logic [CI_W-1:0] v, input coord_t top);
    return (v > CI_W'(top)) ? top : v[COORD_W-1:0];
  endfunction

  function automatic addr_t cell_addr(input coord_t col, input coord_t row,
                                      input coord_t stride);
    return addr_t'(row) * addr_t'(stride) + addr_t'(col);
  endfunction

  // a*(65536-f) + b*f folded into one multiply
  function automatic logic [23:0] mix_row(input logic [7:0] a, input logic [7:0] b,
                                          input logic [15:0] f);
    logic signed [8:0]  d;
    logic signed [25:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    s = $signed({2'b0, a, 16'b0}) + d * $signed({1'b0, f});
    return s[23:0];
  endfunction

  // bg*(65280-w) + src*w folded into one multiply
  function automatic logic [23:0] blend_num(input logic [7:0] bg, input logic [7:0] src,
                                            input logic [15:0] w);
    logic signed [8:0]  d;
    logic signed [25:0] s;
    d = $signed({1'b0, src}) - $signed({1'b0, bg});
    s = $signed({2'b0, bg, 16'b0}) - $signed({10'b0, bg, 8'b0})
        + d * $signed({1'b0, w});
    return s[23:0];
  endfunction

  // floor(n / 65280): shift out 256, then divide by 255 with a reciprocal trick
  function automatic logic [7:0] div_full(input logic [23:0] n);
    logic [15:0] q;
    logic [16:0] s;
    q = n[23:8];
    s = {1'b0, q} + 17'd1 + {9'b0, q[15:8]};
    return s[15:8];
  endfunction

  logic [STEP_W-1:0] x_step_r, y_step_r;
  logic [DIM_W-1:0]  grid_width_r, grid_height_r;
  coord_t            gw_eff, gh_eff, stride;

  logic [8:1] v_r, v_nxt, adv;

  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  s3_t       s3_r, s3_nxt;
  s4_t       s4_r, s4_nxt;
  s5_t       s5_r, s5_nxt;
  s6_t       s6_r, s6_nxt;
  s7_t       s7_r, s7_nxt;
  out_item_t s8_r, s8_nxt;

  logic [CH_W-1:0] grid_a_r [GRID_DEPTH];
  logic [CH_W-1:0] grid_b_r [GRID_DEPTH];
  logic [CH_W-1:0] c00_r, c10_r, c01_r, c11_r;
  logic            grid_we;

  logic signed [24:0] dt;
  logic signed [41:0] wsum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r      <= STEP_RESET;
      y_step_r      <= STEP_RESET;
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_STEP:      x_step_r      <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:      y_step_r      <= cfg_data[STEP_W-1:0];
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  assign gw_eff = eff_size(grid_width_r);
  assign gh_eff = eff_size(grid_height_r);
  assign stride = gw_eff + COORD_W'(1);

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[8] = !v_r[8] || out_ch.ready;
    for (int k = 7; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k + 1];
    end
  end

  always_comb begin
    v_nxt    = {v_r[7:1], in_ch.valid};
    // loads end at the grid write
    v_nxt[5] = v_r[4] && (s4_r.op == OP_BLEND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= 8; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  assign in_ch.ready  = adv[1];
  assign out_ch.valid = v_r[8];
  assign out_ch.data  = s8_r;

  // stage 1: scale position into grid units
  always_comb begin
    s1_nxt.op   = in_ch.data.opcode;
    s1_nxt.lidx = in_ch.data.load_index;
    s1_nxt.lwt  = in_ch.data.load_weight;
    s1_nxt.pix  = '{px: in_ch.data.pixel_x, py: in_ch.data.pixel_y,
                    sr: in_ch.data.src_red, sg: in_ch.data.src_green,
                    sb: in_ch.data.src_blue, br: in_ch.data.bg_red,
                    bgc: in_ch.data.bg_green, bb: in_ch.data.bg_blue};
    s1_nxt.gx   = {{STEP_W{1'b0}}, in_ch.data.pixel_x} * {{PIX_W{1'b0}}, x_step_r};
    s1_nxt.gy   = {{STEP_W{1'b0}}, in_ch.data.pixel_y} * {{PIX_W{1'b0}}, y_step_r};
  end

  // stage 2: corner columns and rows, clamped to the grid edge
  always_comb begin
    s2_nxt.op   = s1_r.op;
    s2_nxt.lidx = s1_r.lidx;
    s2_nxt.lwt  = s1_r.lwt;
    s2_nxt.pix  = s1_r.pix;
    s2_nxt.x0   = sat_coord({1'b0, s1_r.gx[PROD_W-1:16]}, gw_eff);
    s2_nxt.x1   = sat_coord({1'b0, s1_r.gx[PROD_W-1:16]} + CI_W'(1), gw_eff);
    s2_nxt.y0   = sat_coord({1'b0, s1_r.gy[PROD_W-1:16]}, gh_eff);
    s2_nxt.y1   = sat_coord({1'b0, s1_r.gy[PROD_W-1:16]} + CI_W'(1), gh_eff);
    s2_nxt.fx   = s1_r.gx[15:0];
    s2_nxt.fy   = s1_r.gy[15:0];
  end

  // stage 3: corner addresses
  always_comb begin
    s3_nxt.op   = s2_r.op;
    s3_nxt.lidx = s2_r.lidx;
    s3_nxt.lwt  = s2_r.lwt;
    s3_nxt.pix  = s2_r.pix;
    s3_nxt.a00  = cell_addr(s2_r.x0, s2_r.y0, stride);
    s3_nxt.a10  = cell_addr(s2_r.x1, s2_r.y0, stride);
    s3_nxt.a01  = cell_addr(s2_r.x0, s2_r.y1, stride);
    s3_nxt.a11  = cell_addr(s2_r.x1, s2_r.y1, stride);
    s3_nxt.fx   = s2_r.fx;
    s3_nxt.fy   = s2_r.fy;
  end

  // stage 4: grid access, loads write both copies in item order
  assign grid_we = adv[4] && v_r[3] && (s3_r.op == OP_LOAD)
                   && (s3_r.lidx < LIDX_W'(GRID_DEPTH));

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_a_r[addr_t'(s3_r.lidx)] <= s3_r.lwt;
      grid_b_r[addr_t'(s3_r.lidx)] <= s3_r.lwt;
    end
    if (adv[4]) begin
      c00_r <= grid_a_r[s3_r.a00];
      c10_r <= grid_a_r[s3_r.a10];
      c01_r <= grid_b_r[s3_r.a01];
      c11_r <= grid_b_r[s3_r.a11];
    end
  end

  always_comb begin
    s4_nxt.op  = s3_r.op;
    s4_nxt.pix = s3_r.pix;
    s4_nxt.fx  = s3_r.fx;
    s4_nxt.fy  = s3_r.fy;
  end

  // stage 5: horizontal interpolation of both rows
  always_comb begin
    s5_nxt.pix = s4_r.pix;
    s5_nxt.top = mix_row(c00_r, c10_r, s4_r.fx);
    s5_nxt.bot = mix_row(c01_r, c11_r, s4_r.fx);
    s5_nxt.fy  = s4_r.fy;
  end

  // stage 6: vertical interpolation, keep 8 fraction bits of the byte weight
  always_comb begin
    dt         = $signed({1'b0, s5_r.bot}) - $signed({1'b0, s5_r.top});
    wsum       = $signed({2'b0, s5_r.top, 16'b0}) + dt * $signed({1'b0, s5_r.fy});
    s6_nxt.pix = s5_r.pix;
    s6_nxt.w   = wsum[39:24];
  end

  // stage 7: per-channel numerators
  always_comb begin
    s7_nxt.px = s6_r.pix.px;
    s7_nxt.py = s6_r.pix.py;
    s7_nxt.nr = blend_num(s6_r.pix.br, s6_r.pix.sr, s6_r.w);
    s7_nxt.ng = blend_num(s6_r.pix.bgc, s6_r.pix.sg, s6_r.w);
    s7_nxt.nb = blend_num(s6_r.pix.bb, s6_r.pix.sb, s6_r.w);
    s7_nxt.nz = (s6_r.w != '0);
  end

  // stage 8: divide by full weight, zero weight skips the pixel
  always_comb begin
    s8_nxt.write_back = s7_r.nz;
    s8_nxt.out_x      = s7_r.px;
    s8_nxt.out_y      = s7_r.py;
    s8_nxt.out_red    = s7_r.nz ? div_full(s7_r.nr) : '0;
    s8_nxt.out_green  = s7_r.nz ? div_full(s7_r.ng) : '0;
    s8_nxt.out_blue   = s7_r.nz ? div_full(s7_r.nb) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) s1_r <= s1_nxt;
    if (adv[2]) s2_r <= s2_nxt;
    if (adv[3]) s3_r <= s3_nxt;
    if (adv[4]) s4_r <= s4_nxt;
    if (adv[5]) s5_r <= s5_nxt;
    if (adv[6]) s6_r <= s6_nxt;
    if (adv[7]) s7_r <= s7_nxt;
    if (adv[8]) s8_r <= s8_nxt;
  end

  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
    !v_r[8] |-> in_ch.ready
  ) else $error("input stalled while the output stage is empty");

  a_weight_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    v_r[6] |-> (s6_r.w <= FULL_WEIGHT)
  ) else $error("interpolated weight above full weight");

  a_corner_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (v_r[4] && !adv[4]) |=> $stable({c00_r, c10_r, c01_r, c11_r})
  ) else $error("corner weights changed under a held stage");

  a_skip_clears_color: assert property (
    @(posedge clk) disable iff (!rst_n)
    (v_r[7] && adv[8] && !s7_r.nz) |=>
      (out_ch.valid && !out_ch.data.write_back && out_ch.data.out_red == '0
       && out_ch.data.out_green == '0 && out_ch.data.out_blue == '0)
  ) else $error("skipped pixel carries color");

endmodule

// ===== tb/sv/bilinear_weighted_texel_blend_test.sv =====
// self-checking testbench for the bilinear texel blender: random loads and blends vs a predictor
`timescale 1ns / 100ps

module bilinear_weighted_texel_blend_test;
  import bwtb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bwtb_in_if in_ch ();
  bwtb_out_if out_ch ();

  bilinear_weighted_texel_blend u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the configuration and the weight grid
  logic [STEP_W-1:0] x_step_q = STEP_RESET;
  logic [STEP_W-1:0] y_step_q = STEP_RESET;
  logic [DIM_W-1:0] grid_w_q = DIM_RESET;
  logic [DIM_W-1:0] grid_h_q = DIM_RESET;
  logic [CH_W-1:0] grid_mem [GRID_DEPTH];
  bit loaded [GRID_DEPTH];

  in_item_t item_queue [$];
  out_item_t expected_pixels [$];
  out_item_t want_px;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int queued_count = 0;
  bit in_fire = 1'b0;
  bit stall_request = 1'b0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID_MAX) return GRID_MAX;
    return r;
  endfunction

  // grid addresses of the four corners around a pixel, plus the fractions
  function automatic void locate(input logic [PIX_W-1:0] px, py,
                                 output int unsigned a00, a10, a01, a11,
                                 output logic [15:0] fx, fy);
    logic [63:0] gx, gy, cx, cy;
    int unsigned gwe, ghe, stride, x0, x1, y0, y1;
    gwe = eff_dim(grid_w_q);
    ghe = eff_dim(grid_h_q);
    stride = gwe + 1;
    gx = 64'(px) * 64'(x_step_q);
    gy = 64'(py) * 64'(y_step_q);
    fx = gx[15:0];
    fy = gy[15:0];
    cx = gx >> 16;
    cy = gy >> 16;
    x0 = (cx > 64'(gwe)) ? gwe : cx[31:0];
    x1 = (cx + 1 > 64'(gwe)) ? gwe : cx[31:0] + 1;
    y0 = (cy > 64'(ghe)) ? ghe : cy[31:0];
    y1 = (cy + 1 > 64'(ghe)) ? ghe : cy[31:0] + 1;
    a00 = x0 + y0 * stride;
    a10 = x1 + y0 * stride;
    a01 = x0 + y1 * stride;
    a11 = x1 + y1 * stride;
  endfunction

  function automatic logic [CH_W-1:0] mix_chan(input logic [CH_W-1:0] bg, src,
                                               input logic [63:0] w);
    logic [63:0] acc;
    acc = 64'(bg) * (64'(FULL_WEIGHT) - w) + 64'(src) * w;
    return 8'(acc / 64'(FULL_WEIGHT));
  endfunction

  function automatic out_item_t predict_pixel(input in_item_t it);
    int unsigned a00, a10, a01, a11;
    logic [15:0] fx, fy;
    logic [63:0] top, bot, w;
    out_item_t r;
    locate(it.pixel_x, it.pixel_y, a00, a10, a01, a11, fx, fy);
    top = 64'(grid_mem[a00]) * (64'd65536 - 64'(fx)) + 64'(grid_mem[a10]) * 64'(fx);
    bot = 64'(grid_mem[a01]) * (64'd65536 - 64'(fx)) + 64'(grid_mem[a11]) * 64'(fx);
    w = (top * (64'd65536 - 64'(fy)) + bot * 64'(fy)) >> 24;
    if (w > 64'(FULL_WEIGHT)) w = 64'(FULL_WEIGHT);
    r.out_x = it.pixel_x;
    r.out_y = it.pixel_y;
    if (w == 0) begin
      r.write_back = 1'b0;
      r.out_red = '0;
      r.out_green = '0;
      r.out_blue = '0;
    end else if (w == 64'(FULL_WEIGHT)) begin
      r.write_back = 1'b1;
      r.out_red = it.src_red;
      r.out_green = it.src_green;
      r.out_blue = it.src_blue;
    end else begin
      r.write_back = 1'b1;
      r.out_red = mix_chan(it.bg_red, it.src_red, w);
      r.out_green = mix_chan(it.bg_green, it.src_green, w);
      r.out_blue = mix_chan(it.bg_blue, it.src_blue, w);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // input side: transfer seen at the rising edge, next item offered at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_fire = 1'b1;
      if (in_ch.data.opcode == OP_LOAD) begin
        if (in_ch.data.load_index < GRID_DEPTH)
          grid_mem[in_ch.data.load_index] = in_ch.data.load_weight;
      end else begin
        expected_pixels = {expected_pixels, predict_pixel(in_ch.data)};
      end
    end
  end

  always @(negedge clk) begin
    if (!in_ch.valid || in_fire) begin
      if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data <= item_queue.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fire = 1'b0;
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result for pixel x %0d y %0d", out_ch.data.out_x, out_ch.data.out_y);
        fail_count++;
      end else begin
        want_px = expected_pixels.pop_front();
        check_field("write_back", want_px.write_back, out_ch.data.write_back);
        check_field("out_x", want_px.out_x, out_ch.data.out_x);
        check_field("out_y", want_px.out_y, out_ch.data.out_y);
        check_field("out_red", want_px.out_red, out_ch.data.out_red);
        check_field("out_green", want_px.out_green, out_ch.data.out_green);
        check_field("out_blue", want_px.out_blue, out_ch.data.out_blue);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_request) begin
      stall_left = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [CH_W-1:0] rand_weight();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned coord_limit(input logic [STEP_W-1:0] step,
                                              input int unsigned dim);
    logic [63:0] q;
    if (step == 0) return 65535;
    q = (64'(dim + 1) << 16) / 64'(step);
    return (q > 64'd65535) ? 65535 : q[31:0];
  endfunction

  // most coordinates land inside the grid, the rest anywhere
  function automatic logic [PIX_W-1:0] rand_coord(input int unsigned lim);
    if ($urandom_range(99) < 60) return 16'($urandom_range(0, lim));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic push_load(input int unsigned idx, input logic [CH_W-1:0] wt);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.opcode = OP_LOAD;
    it.load_index = LIDX_W'(idx);
    it.load_weight = wt;
    if (idx < GRID_DEPTH) loaded[idx] = 1'b1;
    item_queue = {item_queue, it};
    queued_count++;
  endtask

  task automatic cover_addr(input int unsigned a);
    if (!loaded[a]) push_load(a, rand_weight());
  endtask

  // a blend never reads a grid entry that has not been loaded first
  task automatic add_blend(input logic [PIX_W-1:0] px, py, input logic [23:0] src, bg);
    int unsigned a00, a10, a01, a11;
    logic [15:0] fx, fy;
    in_item_t it;
    locate(px, py, a00, a10, a01, a11, fx, fy);
    cover_addr(a00);
    cover_addr(a10);
    cover_addr(a01);
    cover_addr(a11);
    it.opcode = OP_BLEND;
    it.load_index = LIDX_W'($urandom);
    it.load_weight = 8'($urandom);
    it.pixel_x = px;
    it.pixel_y = py;
    {it.src_red, it.src_green, it.src_blue} = src;
    {it.bg_red, it.bg_green, it.bg_blue} = bg;
    item_queue = {item_queue, it};
    queued_count++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_X_STEP: x_step_q = val;
      CFG_Y_STEP: y_step_q = val;
      CFG_GRID_WIDTH: grid_w_q = val[DIM_W-1:0];
      CFG_GRID_HEIGHT: grid_h_q = val[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (item_queue.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // n counts every queued item, grid loads for uncovered corners included
  task automatic run_random(input int n);
    int unsigned region, lx, ly, pick;
    int target;
    region = (eff_dim(grid_w_q) + 1) * (eff_dim(grid_h_q) + 1);
    lx = coord_limit(x_step_q, eff_dim(grid_w_q));
    ly = coord_limit(y_step_q, eff_dim(grid_h_q));
    target = queued_count + n;
    while (queued_count < target) begin
      pick = $urandom_range(99);
      if (pick < 3)
        push_load($urandom_range(GRID_DEPTH, 8191), 8'($urandom));
      else if (pick < 10)
        push_load($urandom_range(0, region - 1), rand_weight());
      else if (pick < 15)
        push_load($urandom_range(0, GRID_DEPTH - 1), rand_weight());
      else
        add_blend(rand_coord(lx), rand_coord(ly), 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic run_phase(input logic [STEP_W-1:0] xs, ys, input logic [DIM_W-1:0] gw, gh,
                           input int send, recv, n, input bit press);
    write_reg(CFG_X_STEP, xs);
    write_reg(CFG_Y_STEP, ys);
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(gw));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(gh));
    send_idle_pct = send;
    recv_stall_pct = recv;
    @(posedge clk);
    if (press) stall_request = 1'b1;
    run_random(n);
    drain();
  endtask

  initial begin
    int send_tab [4];
    int recv_tab [4];
    logic [STEP_W-1:0] xs, ys;
    logic [DIM_W-1:0] gw, gh;
    send_tab = '{0, 87, 0, 24};
    recv_tab = '{0, 0, 87, 24};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_X_STEP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset configuration
    push_load(0, 8'd255);
    push_load(1, 8'd255);
    push_load(65, 8'd255);
    push_load(66, 8'd255);
    add_blend(16'd0, 16'd0, 24'h123456, 24'hABCDEF);          // full weight
    add_blend(16'd32, 16'd32, 24'hFFFFFF, 24'h000000);        // half fractions, all corners full
    push_load(4224, 8'd0);
    push_load(GRID_DEPTH, 8'd255);                            // out of range, ignored
    push_load(8191, 8'd255);
    add_blend(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);    // past both edges, zero weight
    push_load(64, 8'd128);
    push_load(129, 8'd1);
    add_blend(16'hFFFF, 16'd0, 24'hFFFFFF, 24'h000000);       // column saturated
    add_blend(16'hFFFF, 16'd48, 24'h000000, 24'hFFFFFF);
    push_load(4160, 8'd200);
    push_load(4161, 8'd7);
    add_blend(16'd40, 16'hFFFF, 24'h80FF01, 24'h7F00FE);      // row saturated
    push_load(0, 8'd0);
    add_blend(16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);          // zero weight after overwrite
    add_blend(16'd1, 16'd1, 24'h00FF80, 24'hFF0040);
    drain();

    run_phase(24'h010000, 24'h010000, 7'd4, 7'd4, 0, 0, 250, 1'b0);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 7'd127, 7'd1, 87, 0, 200, 1'b0);
    run_phase(24'h000000, 24'h000000, 7'd0, 7'd0, 0, 87, 150, 1'b0);
    run_phase(24'($urandom_range(0, 1 << 17)), 24'($urandom_range(0, 1 << 17)),
              7'd1, 7'd64, 24, 24, 250, 1'b0);
    // long receiver hold-off while the sender keeps offering
    run_phase(24'($urandom_range(0, 1 << 18)), 24'($urandom_range(0, 1 << 18)),
              7'd64, 7'd64, 0, 0, 300, 1'b1);
    for (int k = 0; k < 4; k++) begin
      xs = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
      ys = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
      gw = $urandom_range(1) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(0, 127));
      gh = $urandom_range(1) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(0, 127));
      run_phase(xs, ys, gw, gh, send_tab[k], recv_tab[k], 200, 1'b0);
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bwtb_pkg.sv
rtl/bwtb_in_if.sv
rtl/bwtb_out_if.sv
rtl/bilinear_weighted_texel_blend.sv
tb/sv/bilinear_weighted_texel_blend_test.sv
